[rtl/ec_affine_point_add_sub_assert.svh]
// ---------------------------------------------------------------------------
// ec point add/sub assertion macros
// shared concurrent assertion helpers, empty when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef EC_AFFINE_POINT_ADD_SUB_ASSERT_SVH
`define EC_AFFINE_POINT_ADD_SUB_ASSERT_SVH
`ifndef SYNTH
`define ECA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ECA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ECA_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ECA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[rtl/eca_pkg.sv]
// ---------------------------------------------------------------------------
// eca_pkg
// shared types and codes for the ec point add/sub block
// ---------------------------------------------------------------------------
package eca_pkg;

    localparam int unsigned REG_MODULUS = 0;
    localparam int unsigned REG_COEFF_A = 1;

    typedef enum logic [2:0] {
        MOP_MUL = 3'b001,
        MOP_RED = 3'b010,
        MOP_DIV = 3'b100
    } mop_t;

endpackage

[rtl/eca_if.sv]
// ---------------------------------------------------------------------------
// eca channel interfaces
// valid/ready channels for input and result transfers
// ---------------------------------------------------------------------------
interface eca_in_if #(parameter int FIELD_BITS = 16);
    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [FIELD_BITS-1:0] first_x;
    logic [FIELD_BITS-1:0] first_y;
    logic                  first_inf;
    logic [FIELD_BITS-1:0] second_x;
    logic [FIELD_BITS-1:0] second_y;
    logic                  second_inf;
    modport source (output valid, mode, first_x, first_y, first_inf, second_x, second_y,
                    second_inf, input ready);
    modport sink (input valid, mode, first_x, first_y, first_inf, second_x, second_y,
                  second_inf, output ready);
endinterface

interface eca_out_if #(parameter int FIELD_BITS = 16);
    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] result_x;
    logic [FIELD_BITS-1:0] result_y;
    logic                  result_inf;
    logic                  no_inverse;
    modport source (output valid, result_x, result_y, result_inf, no_inverse, input ready);
    modport sink (input valid, result_x, result_y, result_inf, no_inverse, output ready);
endinterface

[rtl/ec_affine_point_add_sub.sv]
// ---------------------------------------------------------------------------
// ec_affine_point_add_sub
// affine point add/subtract over GF(p) with a shared sequential unit
// ---------------------------------------------------------------------------
// One transfer at a time: each item is reduced, compared, inverted by extended
// Euclid and combined on one shift-subtract unit that retires one bit per
// cycle. Every item with a nonzero modulus takes five reductions; a finite
// add then takes three products (six when doubling) plus one divide and one
// product per Euclid step, up to about 1.5*FIELD_BITS steps. in.ready is
// high only when idle and the result register is empty.
module ec_affine_point_add_sub #(
    parameter int FIELD_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       psel,
    input  logic       penable,
    input  logic       pwrite,
    input  logic [2:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready,
    eca_in_if.sink     in_ch,
    eca_out_if.source  out_ch
);
    `include "ec_affine_point_add_sub_assert.svh"

    localparam int W = FIELD_BITS;

    typedef enum logic [19:0] {
        S_IDLE  = 20'd1,
        S_RED   = 20'd2,
        S_CASE  = 20'd4,
        S_DBL1  = 20'd8,
        S_DBL2  = 20'd16,
        S_DBL3  = 20'd32,
        S_EUC   = 20'd64,
        S_EUCM  = 20'd128,
        S_EUCR  = 20'd256,
        S_SLOPE = 20'd512,
        S_SQ    = 20'd1024,
        S_YM    = 20'd2048,
        S_OUT   = 20'd4096,
        S_WAIT  = 20'd8192,
        S_DBL0  = 20'd16384,
        S_EUCS  = 20'd32768,
        S_FIN   = 20'd65536,
        S_YR    = 20'd131072,
        S_AR    = 20'd262144,
        S_POST  = 20'd524288
    } state_t;

    state_t state_reg;
    logic [W-1:0] mod_reg, coa_reg;
    logic [W-1:0] x1_reg, y1_reg, x2_reg, y2_reg, a_reg;
    logic         inf1_reg, inf2_reg, mode_reg;
    logic [2:0]   ridx_reg;
    logic [W-1:0] num_reg, den_reg, s_reg, xr_reg;
    logic [W-1:0] r0_reg, r1_reg, t0_reg, t1_reg, q_reg;
    logic         busy_reg;
    logic         ov_reg;
    logic [W-1:0] ox_reg, oy_reg;
    logic         oinf_reg, oerr_reg;

    logic          u_start;
    eca_pkg::mop_t u_op;
    logic [W-1:0]  u_a, u_b, u_m;
    logic          u_done;
    logic [W-1:0]  u_q, u_r;

    eca_mod_unit #(.FIELD_BITS(W)) u_unit (
        .clk(clk), .rst_n(rst_n), .start(u_start), .op(u_op),
        .opa(u_a), .opb(u_b), .opm(u_m), .done(u_done), .quot(u_q), .rem(u_r)
    );

    function automatic logic [W-1:0] fsub(input logic [W-1:0] u, input logic [W-1:0] v,
                                          input logic [W-1:0] p);
        logic [W:0] d;
        d = {1'b0, u} - {1'b0, v};
        if (d[W])
            d = d + {1'b0, p};
        return d[W-1:0];
    endfunction

    function automatic logic [W-1:0] fadd(input logic [W-1:0] u, input logic [W-1:0] v,
                                          input logic [W-1:0] p);
        logic [W:0] s;
        s = {1'b0, u} + {1'b0, v};
        if (s >= {1'b0, p})
            s = s - {1'b0, p};
        return s[W-1:0];
    endfunction

    // config port
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_comb
    begin
        case (paddr)
            3'(eca_pkg::REG_MODULUS * 4): prdata = 32'(mod_reg);
            3'(eca_pkg::REG_COEFF_A * 4): prdata = 32'(coa_reg);
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg <= W'(97);
            coa_reg <= W'(2);
        end
        else if (cfg_wr)
        begin
            if (paddr == 3'(eca_pkg::REG_MODULUS * 4))
                mod_reg <= pwdata[W-1:0];
            else if (paddr == 3'(eca_pkg::REG_COEFF_A * 4))
                coa_reg <= pwdata[W-1:0];
        end
    end

    assign in_ch.ready     = (state_reg == S_IDLE) && !ov_reg;
    assign out_ch.valid    = ov_reg;
    assign out_ch.result_x   = ox_reg;
    assign out_ch.result_y   = oy_reg;
    assign out_ch.result_inf = oinf_reg;
    assign out_ch.no_inverse = oerr_reg;

    logic [W-1:0] t_neg;
    logic [W-1:0] rd_src;
    always_comb
    begin
        case (ridx_reg)
            3'd0:    rd_src = x1_reg;
            3'd1:    rd_src = y1_reg;
            3'd2:    rd_src = x2_reg;
            3'd3:    rd_src = y2_reg;
            default: rd_src = a_reg;
        endcase
        t_neg = fsub('0, u_r, mod_reg);
    end

    // unit issue: start on the cycle a step is entered (busy_reg low)
    always_comb
    begin
        u_start = 1'b0;
        u_op    = eca_pkg::MOP_RED;
        u_a     = rd_src;
        u_b     = '0;
        u_m     = mod_reg;
        if (!busy_reg)
        begin
            case (state_reg)
                S_RED:
                begin
                    u_start = 1'b1;
                end
                S_DBL0:
                begin
                    u_start = 1'b1; u_op = eca_pkg::MOP_MUL; u_a = x1_reg; u_b = x1_reg;
                end
                S_DBL1:
                begin
                    u_start = 1'b1; u_op = eca_pkg::MOP_MUL; u_a = num_reg; u_b = W'(3);
                end
                S_DBL2:
                begin
                    u_start = 1'b1; u_op = eca_pkg::MOP_MUL; u_a = y1_reg; u_b = W'(2);
                end
                S_EUC:
                begin
                    u_start = 1'b1; u_op = eca_pkg::MOP_DIV; u_a = r0_reg; u_b = r1_reg;
                end
                S_EUCM:
                begin
                    u_start = 1'b1; u_op = eca_pkg::MOP_MUL; u_a = q_reg; u_b = t1_reg;
                end
                S_SLOPE:
                begin
                    u_start = 1'b1; u_op = eca_pkg::MOP_MUL; u_a = num_reg; u_b = t0_reg;
                end
                S_SQ:
                begin
                    u_start = 1'b1; u_op = eca_pkg::MOP_MUL; u_a = s_reg; u_b = s_reg;
                end
                S_YM:
                begin
                    u_start = 1'b1; u_op = eca_pkg::MOP_MUL; u_a = s_reg;
                    u_b = fsub(x1_reg, xr_reg, mod_reg);
                end
                default: u_start = 1'b0;
            endcase
        end
    end

    // t values kept reduced mod p; q*t1 mod p matches the signed recurrence mod p
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            ridx_reg  <= '0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
                ov_reg <= 1'b0;
            if (u_start)
                busy_reg <= 1'b1;
            if (u_done)
                busy_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        x1_reg   <= in_ch.first_x;
                        y1_reg   <= in_ch.first_y;
                        x2_reg   <= in_ch.second_x;
                        y2_reg   <= in_ch.second_y;
                        inf1_reg <= in_ch.first_inf;
                        inf2_reg <= in_ch.second_inf;
                        mode_reg <= in_ch.mode;
                        a_reg    <= coa_reg;
                        ridx_reg <= '0;
                        if (mod_reg == '0)
                        begin
                            ox_reg <= '0; oy_reg <= '0; oinf_reg <= 1'b0; oerr_reg <= 1'b1;
                            ov_reg <= 1'b1;
                        end
                        else
                            state_reg <= S_RED;
                    end
                end
                S_RED:
                begin
                    if (u_done)
                    begin
                        case (ridx_reg)
                            3'd0: x1_reg <= u_r;
                            3'd1: y1_reg <= u_r;
                            3'd2: x2_reg <= u_r;
                            3'd3: y2_reg <= (mode_reg && !inf2_reg) ? t_neg : u_r;
                            default: a_reg <= u_r;
                        endcase
                        if (ridx_reg == 3'd4)
                            state_reg <= S_CASE;
                        else
                            ridx_reg <= ridx_reg + 1'b1;
                    end
                end
                S_CASE:
                begin
                    state_reg <= S_OUT;
                    oerr_reg  <= 1'b0;
                    oinf_reg  <= 1'b0;
                    if (inf1_reg && inf2_reg)
                    begin
                        ox_reg <= '0; oy_reg <= '0; oinf_reg <= 1'b1;
                    end
                    else if (inf1_reg)
                    begin
                        ox_reg <= x2_reg; oy_reg <= y2_reg;
                    end
                    else if (inf2_reg)
                    begin
                        ox_reg <= x1_reg; oy_reg <= y1_reg;
                    end
                    else if (x1_reg == x2_reg && fadd(y1_reg, y2_reg, mod_reg) == '0)
                    begin
                        ox_reg <= '0; oy_reg <= '0; oinf_reg <= 1'b1;
                    end
                    else if (x1_reg == x2_reg && y1_reg == y2_reg)
                        state_reg <= S_DBL0;
                    else
                    begin
                        num_reg   <= fsub(y2_reg, y1_reg, mod_reg);
                        den_reg   <= fsub(x2_reg, x1_reg, mod_reg);
                        state_reg <= S_EUCS;
                    end
                end
                S_DBL0:
                    if (u_done)
                    begin
                        num_reg <= u_r; state_reg <= S_DBL1;
                    end
                S_DBL1:
                    if (u_done)
                    begin
                        num_reg <= fadd(u_r, a_reg, mod_reg); state_reg <= S_DBL2;
                    end
                S_DBL2:
                    if (u_done)
                    begin
                        den_reg <= u_r; state_reg <= S_EUCS;
                    end
                S_EUCS:
                begin
                    r0_reg <= mod_reg; r1_reg <= den_reg;
                    t0_reg <= '0;      t1_reg <= (mod_reg == W'(1)) ? '0 : W'(1);
                    state_reg <= S_EUCR;
                end
                S_EUCR:
                begin
                    if (r1_reg == '0)
                        state_reg <= S_FIN;
                    else
                        state_reg <= S_EUC;
                end
                S_EUC:
                    if (u_done)
                    begin
                        q_reg <= u_q; r0_reg <= r1_reg; r1_reg <= u_r;
                        state_reg <= S_EUCM;
                    end
                S_EUCM:
                    if (u_done)
                    begin
                        t0_reg <= t1_reg;
                        t1_reg <= fsub(t0_reg, u_r, mod_reg);
                        state_reg <= S_EUCR;
                    end
                S_FIN:
                begin
                    if (r0_reg != W'(1))
                    begin
                        ox_reg <= '0; oy_reg <= '0; oinf_reg <= 1'b0; oerr_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_SLOPE;
                end
                S_SLOPE:
                    if (u_done)
                    begin
                        s_reg <= u_r; state_reg <= S_SQ;
                    end
                S_SQ:
                    if (u_done)
                    begin
                        xr_reg <= fsub(fsub(u_r, x1_reg, mod_reg), x2_reg, mod_reg);
                        state_reg <= S_YM;
                    end
                S_YM:
                    if (u_done)
                    begin
                        ox_reg <= xr_reg;
                        oy_reg <= fsub(u_r, y1_reg, mod_reg);
                        oinf_reg <= 1'b0; oerr_reg <= 1'b0;
                        state_reg <= S_OUT;
                    end
                S_OUT:
                begin
                    ov_reg    <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `ECA_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ch.ready, state_reg == S_IDLE)
    `ECA_ASSERT_IMPL(a_err_clean, clk, rst_n, out_ch.valid && out_ch.no_inverse,
                     !out_ch.result_inf && out_ch.result_x == '0)
    `ECA_ASSERT_NEXT(a_no_start_busy, clk, rst_n, busy_reg && !u_done, !u_start || u_done)
endmodule

[rtl/eca_mod_unit.sv]
// ---------------------------------------------------------------------------
// eca_mod_unit
// shared multicycle unit: a*b mod m, a mod m, and a / b with remainder,
// one quotient bit per cycle by restoring shift-subtract
// ---------------------------------------------------------------------------
module eca_mod_unit #(
    parameter int FIELD_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  eca_pkg::mop_t         op,
    input  logic [FIELD_BITS-1:0] opa,
    input  logic [FIELD_BITS-1:0] opb,
    input  logic [FIELD_BITS-1:0] opm,
    output logic                  done,
    output logic [FIELD_BITS-1:0] quot,
    output logic [FIELD_BITS-1:0] rem
);
    localparam int W  = FIELD_BITS;
    localparam int DW = 2 * FIELD_BITS;
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] num_reg, num_next;
    logic [W:0]    acc_reg, acc_next;
    logic [W-1:0]  den_reg;
    logic [W-1:0]  q_reg, q_next;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [W:0]    shifted;
    logic [W:0]    diff;

    always_comb
    begin
        shifted  = {acc_reg[W-1:0], num_reg[DW-1]};
        diff     = shifted - {1'b0, den_reg};
        num_next = {num_reg[DW-2:0], 1'b0};
        if (!diff[W])
        begin
            acc_next = diff;
            q_next   = {q_reg[W-2:0], 1'b1};
        end
        else
        begin
            acc_next = shifted;
            q_next   = {q_reg[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                case (op)
                    eca_pkg::MOP_MUL:
                    begin
                        num_reg <= DW'(opa) * DW'(opb);
                        den_reg <= opm;
                        cnt_reg <= CW'(DW);
                    end
                    eca_pkg::MOP_RED:
                    begin
                        num_reg <= {opa, {W{1'b0}}};
                        den_reg <= opm;
                        cnt_reg <= CW'(W);
                    end
                    default:
                    begin
                        num_reg <= {opa, {W{1'b0}}};
                        den_reg <= opb;
                        cnt_reg <= CW'(W);
                    end
                endcase
                acc_reg <= '0;
                q_reg   <= '0;
            end
            else if (busy_reg)
            begin
                num_reg <= num_next;
                acc_reg <= acc_next;
                q_reg   <= q_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = acc_reg[W-1:0];
endmodule
